// ===== hw/rtl/evip_pkg.sv =====
`timescale 1ns / 1ps

package evip_pkg;

    localparam logic [15:0] TPID_CTAG  = 16'h8100;
    localparam logic [15:0] TPID_STAG  = 16'h88A8;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

    localparam logic [1:0] MAX_TAGS = 2'd2;
    localparam logic [11:0] VID_MASK = 12'h0fff;

    // byte positions relative to the start of each header
    localparam logic [5:0] ETH_TYPE_HI  = 6'd12;
    localparam logic [5:0] ETH_TYPE_LO  = 6'd13;
    localparam logic [5:0] TAG_VID_HI   = 6'd0;
    localparam logic [5:0] TAG_VID_LO   = 6'd1;
    localparam logic [5:0] TAG_TYPE_HI  = 6'd2;
    localparam logic [5:0] TAG_TYPE_LO  = 6'd3;
    localparam logic [5:0] IP4_VER_IHL  = 6'd0;
    localparam logic [5:0] IP4_PROTO    = 6'd9;
    localparam logic [5:0] IP4_BASE_LEN = 6'd20;
    localparam logic [3:0] IP4_MIN_IHL  = 4'd5;
    localparam logic [5:0] IP6_NXT_HDR  = 6'd6;
    localparam logic [5:0] IP6_LAST     = 6'd39;
    localparam logic [5:0] ICMP_SEQ_HI  = 6'd6;
    localparam logic [5:0] ICMP_SEQ_LO  = 6'd7;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int M_DATA_W = 72;

    typedef enum logic [2:0] {
        PH_ETH,
        PH_TAG,
        PH_IP4,
        PH_IP6,
        PH_ICMP,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        L3_OTHER = 2'd0,
        L3_IPV4  = 2'd1,
        L3_IPV6  = 2'd2
    } l3_kind_t;

    // raw parse state of one frame, handed from front to back
    typedef struct packed {
        logic        eth_done;
        logic [15:0] proto;
        logic [1:0]  tags;
        logic [11:0] vid0;
        logic [11:0] vid1;
        logic        l3_ok;
        logic [7:0]  next_proto;
        logic        seq_ok;
        logic [15:0] seq;
    } parse_rec_t;

endpackage

// ===== hw/rtl/evip_front.sv =====
`timescale 1ns / 1ps

module evip_front import evip_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] byte_data,
    input  logic       byte_last,
    input  logic       q_full,
    output logic       rec_push,
    output parse_rec_t rec
);

    phase_t      phase_reg, phase_next, phase_step, link_phase;
    logic [5:0]  rel_reg, rel_next;
    logic [15:0] proto_reg, proto_next, proto_new;
    logic [1:0]  tags_reg, tags_next, tags_new;
    logic [11:0] vid0_reg, vid0_next, vid1_reg, vid1_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [7:0]  nxt_reg, nxt_next;
    logic [15:0] seq_reg, seq_next;
    logic        eth_reg, eth_next, l3_reg, l3_next, seqok_reg, seqok_next;
    logic        accept, ip4_end;

    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;
    assign ip4_end    = (rel_reg + 6'd1) == ihl_reg;

    // header that follows the ethernet header or a completed tag
    always_comb begin
        proto_new = (phase_reg == PH_TAG) ? {nxt_reg, byte_data} : {proto_reg[15:8], byte_data};
        tags_new  = (phase_reg == PH_TAG) ? tags_reg + 2'd1 : tags_reg;
        priority if (((proto_new == TPID_CTAG) || (proto_new == TPID_STAG))
                     && (tags_new < MAX_TAGS)) begin
            link_phase = PH_TAG;
        end else if (proto_new == ETYPE_IPV4) begin
            link_phase = PH_IP4;
        end else if (proto_new == ETYPE_IPV6) begin
            link_phase = PH_IP6;
        end else begin
            link_phase = PH_IDLE;
        end
    end

    // next state
    always_comb begin
        phase_step = phase_reg;
        unique case (phase_reg)
            PH_ETH: begin
                if (rel_reg == ETH_TYPE_LO) phase_step = link_phase;
            end
            PH_TAG: begin
                if (rel_reg == TAG_TYPE_LO) phase_step = link_phase;
            end
            PH_IP4: begin
                priority if ((rel_reg == IP4_VER_IHL) && (byte_data[3:0] < IP4_MIN_IHL)) begin
                    phase_step = PH_IDLE;
                end else if (ip4_end) begin
                    phase_step = PH_ICMP;
                end else begin
                    phase_step = phase_reg;
                end
            end
            PH_IP6: begin
                if (rel_reg == IP6_LAST) phase_step = PH_ICMP;
            end
            PH_ICMP: begin
                if (rel_reg == ICMP_SEQ_LO) phase_step = PH_IDLE;
            end
            PH_IDLE: begin
                phase_step = phase_reg;
            end
            default: begin
                phase_step = phase_reg;
            end
        endcase
        phase_next = byte_last ? PH_ETH : phase_step;
    end

    // field capture
    always_comb begin
        proto_next = proto_reg;
        tags_next  = tags_reg;
        vid0_next  = vid0_reg;
        vid1_next  = vid1_reg;
        ihl_next   = ihl_reg;
        nxt_next   = nxt_reg;
        seq_next   = seq_reg;
        eth_next   = eth_reg;
        l3_next    = l3_reg;
        seqok_next = seqok_reg;
        rel_next   = rel_reg;
        // a tag followed by another tag restarts the position too
        if ((phase_step != phase_reg)
            || ((phase_reg == PH_TAG) && (rel_reg == TAG_TYPE_LO))) begin
            rel_next = '0;
        end else if (phase_reg != PH_IDLE) begin
            rel_next = rel_reg + 6'd1;
        end
        unique case (phase_reg)
            PH_ETH: begin
                if (rel_reg == ETH_TYPE_HI) proto_next[15:8] = byte_data;
                if (rel_reg == ETH_TYPE_LO) begin
                    proto_next = proto_new;
                    eth_next   = 1'b1;
                    if (link_phase == PH_IP4) ihl_next = IP4_BASE_LEN;
                end
            end
            PH_TAG: begin
                if (rel_reg == TAG_VID_HI) begin
                    if (tags_reg == 2'd0) vid0_next = {byte_data[3:0], 8'h00} & VID_MASK;
                    else vid1_next = {byte_data[3:0], 8'h00} & VID_MASK;
                end
                if (rel_reg == TAG_VID_LO) begin
                    if (tags_reg == 2'd0) vid0_next[7:0] = byte_data;
                    else vid1_next[7:0] = byte_data;
                end
                if (rel_reg == TAG_TYPE_HI) nxt_next = byte_data;
                if (rel_reg == TAG_TYPE_LO) begin
                    proto_next = proto_new;
                    nxt_next   = '0;
                    tags_next  = tags_new;
                    if (link_phase == PH_IP4) ihl_next = IP4_BASE_LEN;
                end
            end
            PH_IP4: begin
                if (rel_reg == IP4_VER_IHL) ihl_next = {byte_data[3:0], 2'b00};
                if (rel_reg == IP4_PROTO) nxt_next = byte_data;
                if (phase_step == PH_ICMP) l3_next = 1'b1;
            end
            PH_IP6: begin
                if (rel_reg == IP6_NXT_HDR) nxt_next = byte_data;
                if (phase_step == PH_ICMP) l3_next = 1'b1;
            end
            PH_ICMP: begin
                if (rel_reg == ICMP_SEQ_HI) seq_next[15:8] = byte_data;
                if (rel_reg == ICMP_SEQ_LO) begin
                    seq_next[7:0] = byte_data;
                    seqok_next    = 1'b1;
                end
            end
            PH_IDLE: begin
                rel_next = rel_reg;
            end
            default: begin
                rel_next = rel_reg;
            end
        endcase
    end

    assign rec_push = accept && byte_last;

    always_comb begin
        rec.eth_done   = eth_next;
        rec.proto      = proto_next;
        rec.tags       = tags_next;
        rec.vid0       = vid0_next;
        rec.vid1       = vid1_next;
        rec.l3_ok      = l3_next;
        rec.next_proto = nxt_next;
        rec.seq_ok     = seqok_next;
        rec.seq        = seq_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || rec_push) begin
            phase_reg <= PH_ETH;
            rel_reg   <= '0;
            proto_reg <= '0;
            tags_reg  <= '0;
            vid0_reg  <= '0;
            vid1_reg  <= '0;
            ihl_reg   <= '0;
            nxt_reg   <= '0;
            seq_reg   <= '0;
            eth_reg   <= 1'b0;
            l3_reg    <= 1'b0;
            seqok_reg <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            rel_reg   <= rel_next;
            proto_reg <= proto_next;
            tags_reg  <= tags_next;
            vid0_reg  <= vid0_next;
            vid1_reg  <= vid1_next;
            ihl_reg   <= ihl_next;
            nxt_reg   <= nxt_next;
            seq_reg   <= seq_next;
            eth_reg   <= eth_next;
            l3_reg    <= l3_next;
            seqok_reg <= seqok_next;
        end
    end

endmodule

// ===== hw/rtl/evip_queue.sv =====
`timescale 1ns / 1ps

module evip_queue import evip_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  parse_rec_t push_rec,
    input  logic       pop,
    output parse_rec_t pop_rec,
    output logic       not_empty,
    output logic       full
);

    parse_rec_t          ent_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == QCNT_W'(QDEPTH);
    assign pop_rec   = ent_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + QCNT_W'(1);
        if (pop && !push) count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) ent_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("request queue underflow");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH)) else $error("request queue count out of range");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("request queue count lost a push");

endmodule

// ===== hw/rtl/evip_back.sv =====
`timescale 1ns / 1ps

module evip_back import evip_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  parse_rec_t          q_rec,
    output logic                q_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    l3_kind_t            kind;
    logic                pass;
    logic [15:0]         ethertype;
    logic [11:0]         outer_vid, inner_vid;
    logic [7:0]          l4_proto;
    logic [15:0]         seq;

    assign q_pop = q_not_empty && (!m_valid_reg || m_axis_tready);

    always_comb begin
        priority if (q_rec.eth_done && (q_rec.proto == ETYPE_IPV4)) begin
            kind = L3_IPV4;
        end else if (q_rec.eth_done && (q_rec.proto == ETYPE_IPV6)) begin
            kind = L3_IPV6;
        end else begin
            kind = L3_OTHER;
        end
        pass      = (kind != L3_OTHER) && (!q_rec.l3_ok || !q_rec.seq_ok || q_rec.seq[0]);
        ethertype = q_rec.eth_done ? q_rec.proto : 16'hFFFF;
        outer_vid = (q_rec.tags > 2'd0) ? q_rec.vid0 : 12'd0;
        inner_vid = (q_rec.tags > 2'd1) ? q_rec.vid1 : 12'd0;
        l4_proto  = q_rec.l3_ok ? q_rec.next_proto : 8'd0;
        seq       = q_rec.seq_ok ? q_rec.seq : 16'd0;
        m_data_next = {1'b0, seq, q_rec.seq_ok, l4_proto, q_rec.l3_ok, kind,
                       inner_vid, outer_vid, q_rec.tags, ethertype, pass};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== hw/rtl/eth_vlan_ip_icmp_header_parser_top.sv =====
`timescale 1ns / 1ps

// ethernet / vlan / ipv4 / ipv6 / icmp header parser with pass-or-drop verdict
// s_axis: one frame byte per request, wire order, s_axis_tlast on the final byte
// m_axis: one verdict request per frame, sent after the final byte
// the front parser keeps a byte-relative position per header and takes one
// byte every cycle while the queue is not full; on the final byte it pushes
// the raw parse state into a two-entry queue and clears itself for the next
// frame in the same cycle; the back end turns a queued entry into the verdict
// in an output register; m_axis_tvalid rises once the entry has left the queue
// throughput: one byte per cycle while s_axis_tready is high, back to back
// across frame boundaries; s_axis_tready only falls when two parse records
// are queued behind a held output, i.e. when the receiver stalls; bytes then wait
// reset (aresetn low, synchronous) empties queue and output and puts the
// parser at the start of a frame
module eth_vlan_ip_icmp_header_parser_top import evip_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,  // data_byte
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // pass_frame, inner_ethertype, tag_count, outer_vlan_id, inner_vlan_id,
    // l3_kind, l3_ok, l4_protocol, seq_ok, icmp_seq, zero pad
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    parse_rec_t push_rec, pop_rec;
    logic       push, pop, q_not_empty, q_full;

    evip_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_axis_tvalid),
        .byte_ready (s_axis_tready),
        .byte_data  (s_axis_tdata),
        .byte_last  (s_axis_tlast),
        .q_full     (q_full),
        .rec_push   (push),
        .rec        (push_rec)
    );

    evip_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .pop_rec   (pop_rec),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    evip_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_rec         (pop_rec),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
